// ===== sv/rgb_led_matrix_scan_driver_defines.svh =====
// ----------------------------------------------------------------------------
// rgb led matrix scan driver assertion macros
// shared property wrappers, synchronous active-high reset
// ----------------------------------------------------------------------------
`ifndef RGB_LED_MATRIX_SCAN_DRIVER_DEFINES_SVH
`define RGB_LED_MATRIX_SCAN_DRIVER_DEFINES_SVH

// same-cycle implication
`define RLMSD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RLMSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rlmsd_pkg.sv =====
// ----------------------------------------------------------------------------
// rlmsd_pkg
// types and constants for the rgb led matrix scan driver
// ----------------------------------------------------------------------------
`default_nettype none

package rlmsd_pkg;

  localparam int PANEL_COLUMNS_DEF = 32;
  localparam int SCAN_ROWS_DEF     = 8;

  localparam logic [15:0] HOLD_TICKS_RESET = 16'd100;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [4:0] pixel_x;
    logic [3:0] pixel_y;
    logic [2:0] pixel_colour;
  } item_t;

  typedef struct packed {
    logic [2:0] top_colour;
    logic [2:0] bottom_colour;
    logic [2:0] row_select;
    logic       shift_strobe;
    logic       latch_strobe;
    logic       output_blank;
    logic       frame_end;
  } pin_t;

endpackage

`default_nettype wire

// ===== sv/rgb_led_matrix_scan_driver.sv =====
// ----------------------------------------------------------------------------
// rgb_led_matrix_scan_driver
// Scan driver for a multiplexed rgb led panel with a 3-bit frame buffer.
// One item is taken per clock cycle unless the pin output stalls or the
// clearing pass runs; each tick item gives its pin word in the next cycle
// from the output register, set by the registered reads of both frame
// memories (upper and lower half, same address). Pixel writes give no pin
// word. After reset a clearing pass writes zero to every frame entry
// (SCAN_ROWS * 2**clog2(PANEL_COLUMNS) per memory, 256 for the default 32x16
// panel), during which no item is taken; hold_ticks writes are always taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rgb_led_matrix_scan_driver_defines.svh"

module rgb_led_matrix_scan_driver #(
  parameter int PANEL_COLUMNS = rlmsd_pkg::PANEL_COLUMNS_DEF,
  parameter int SCAN_ROWS     = rlmsd_pkg::SCAN_ROWS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire rlmsd_pkg::item_t item,
  output logic                  pin_valid,
  input  wire logic             pin_ready,
  output rlmsd_pkg::pin_t       pin,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [15:0]      cfg_data
);

  import rlmsd_pkg::*;

  localparam int COL_W  = $clog2(PANEL_COLUMNS);
  localparam int ROW_W  = $clog2(SCAN_ROWS);
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DEPTH  = SCAN_ROWS << COL_W;

  typedef enum logic [1:0] {
    PH_SHIFT,
    PH_LATCH,
    PH_HOLD
  } phase_t;

  // frame memories, one colour per entry
  logic [2:0] top_mem [DEPTH];
  logic [2:0] bot_mem [DEPTH];
  logic [2:0] rd_top;
  logic [2:0] rd_bot;

  logic              clearing;
  logic [ADDR_W-1:0] clear_addr;

  logic [15:0]       hold_ticks;

  phase_t            phase;
  logic [ROW_W-1:0]  scan_row;
  logic [COL_W-1:0]  column_count;
  logic [15:0]       hold_count;

  // output register, colour comes from the memory read registers
  logic [2:0]        o_row;
  logic              o_shift;
  logic              o_latch;
  logic              o_blank;
  logic              o_fend;
  logic              o_shift_next;
  logic              o_latch_next;
  logic              o_blank_next;
  logic              o_fend_next;

  logic              item_xfer;
  logic              tick;
  logic              pix_wr;
  logic [31:0]       px_x;
  logic [31:0]       px_y;
  logic              px_bottom;
  logic [31:0]       px_row;
  logic [ADDR_W-1:0] px_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [2:0]        wr_data;
  logic              top_we;
  logic              bot_we;
  logic [16:0]       hold_limit;
  logic [16:0]       hold_sum;
  logic              hold_last;
  logic              col_last;
  logic              row_last;

  assign cfg_ready  = 1'b1;
  assign item_ready = !clearing && (!pin_valid || pin_ready);
  assign item_xfer  = item_valid && item_ready;
  assign tick       = item_xfer && (item.kind == KIND_TICK);

  always_comb begin
    px_x      = 32'(item.pixel_x);
    px_y      = 32'(item.pixel_y);
    px_bottom = (px_y >= 32'(SCAN_ROWS));
    px_row    = px_bottom ? (px_y - 32'(SCAN_ROWS)) : px_y;
    px_addr   = {px_row[ROW_W-1:0], px_x[COL_W-1:0]};
    pix_wr    = item_xfer && (item.kind == KIND_PIXEL) &&
                (px_x < 32'(PANEL_COLUMNS)) && (px_y < 32'(2 * SCAN_ROWS));
  end

  // clearing pass owns both write ports
  always_comb begin
    wr_addr = clearing ? clear_addr : px_addr;
    wr_data = clearing ? 3'd0 : item.pixel_colour;
    top_we  = clearing || (pix_wr && !px_bottom);
    bot_we  = clearing || (pix_wr && px_bottom);
  end

  assign rd_addr = {scan_row, column_count};

  always_ff @(posedge clk) begin
    if (top_we) begin
      top_mem[wr_addr] <= wr_data;
    end
    if (tick) begin
      rd_top <= top_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (bot_we) begin
      bot_mem[wr_addr] <= wr_data;
    end
    if (tick) begin
      rd_bot <= bot_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + 1'b1;
      if (clear_addr == ADDR_W'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ticks <= HOLD_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      hold_ticks <= cfg_data;
    end
  end

  always_comb begin
    // zero hold behaves as one lit tick
    hold_limit = (hold_ticks == 16'd0) ? 17'd1 : 17'(hold_ticks);
    hold_sum   = 17'(hold_count) + 17'd1;
    hold_last  = (hold_sum >= hold_limit);
    col_last   = (column_count == COL_W'(PANEL_COLUMNS - 1));
    row_last   = (scan_row == ROW_W'(SCAN_ROWS - 1));
  end

  always_comb begin
    o_shift_next = 1'b0;
    o_latch_next = 1'b0;
    o_blank_next = 1'b1;
    o_fend_next  = 1'b0;
    case (phase)
      PH_LATCH: begin
        o_latch_next = 1'b1;
      end
      PH_HOLD: begin
        o_blank_next = 1'b0;
        o_fend_next  = hold_last && row_last;
      end
      default: begin
        o_shift_next = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SHIFT;
      scan_row     <= '0;
      column_count <= '0;
      hold_count   <= '0;
      pin_valid    <= 1'b0;
      o_row        <= '0;
      o_shift      <= 1'b0;
      o_latch      <= 1'b0;
      o_blank      <= 1'b1;
      o_fend       <= 1'b0;
    end else begin
      if (tick) begin
        pin_valid <= 1'b1;
      end else if (pin_valid && pin_ready) begin
        pin_valid <= 1'b0;
      end
      if (tick) begin
        o_row   <= 3'(scan_row);
        o_shift <= o_shift_next;
        o_latch <= o_latch_next;
        o_blank <= o_blank_next;
        o_fend  <= o_fend_next;
        case (phase)
          PH_LATCH: begin
            phase      <= PH_HOLD;
            hold_count <= '0;
          end
          PH_HOLD: begin
            if (hold_last) begin
              scan_row     <= row_last ? '0 : scan_row + 1'b1;
              hold_count   <= '0;
              column_count <= '0;
              phase        <= PH_SHIFT;
            end else begin
              hold_count <= hold_count + 16'd1;
            end
          end
          default: begin
            if (col_last) begin
              column_count <= '0;
              phase        <= PH_LATCH;
            end else begin
              column_count <= column_count + 1'b1;
              phase        <= PH_SHIFT;
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    pin.top_colour    = o_shift ? rd_top : 3'd0;
    pin.bottom_colour = o_shift ? rd_bot : 3'd0;
    pin.row_select    = o_row;
    pin.shift_strobe  = o_shift;
    pin.latch_strobe  = o_latch;
    pin.output_blank  = o_blank;
    pin.frame_end     = o_fend;
  end

  `RLMSD_ASSERT_NOW(a_no_item_while_clearing, clk, rst,
    clearing, !item_ready, "item taken during clearing pass")

  `RLMSD_ASSERT_NEXT(a_latch_then_hold, clk, rst,
    tick && phase == PH_LATCH, phase == PH_HOLD && pin.latch_strobe,
    "latch tick not followed by hold phase")

  `RLMSD_ASSERT_NOW(a_frame_end_on_last_row, clk, rst,
    pin_valid && pin.frame_end,
    !pin.output_blank && pin.row_select == 3'(SCAN_ROWS - 1),
    "frame end outside last lit row")

  `RLMSD_ASSERT_NOW(a_dark_outside_shift, clk, rst,
    pin_valid && !pin.shift_strobe,
    pin.top_colour == 3'd0 && pin.bottom_colour == 3'd0,
    "colour driven outside shift ticks")

endmodule

`default_nettype wire

// ===== test/rgb_led_matrix_scan_driver_tb.sv =====
// ----------------------------------------------------------------------------
// rgb_led_matrix_scan_driver_tb
// Drives pixel writes and scan ticks into the panel scan driver with bursty
// input and a stalling output side. A tracker keeps its own frame buffer and
// scan counters, predicts each pin word and checks it field by field. The
// hold length is changed between phases, including zero, one and the maximum.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_led_matrix_scan_driver_tb;
  import rlmsd_pkg::*;

  localparam int COLS       = PANEL_COLUMNS_DEF;
  localparam int ROWS       = SCAN_ROWS_DEF;
  localparam int IDLE_LIMIT = 4000;
  localparam int LONG_STALL = 80;
  localparam int SETTLE     = 4;
  localparam int PRINT_CAP  = 40;

  typedef enum logic [1:0] {
    PH_SHIFT = 2'd0,
    PH_LATCH = 2'd1,
    PH_HOLD  = 2'd2
  } scan_phase_e;

  class scan_pin_tracker;
    logic [2:0]  frame [2*ROWS][COLS];
    scan_phase_e phase;
    logic [2:0]  row;
    logic [4:0]  col;
    logic [15:0] hold_cnt;
    logic [15:0] hold_ticks;
    pin_t        pending_pins[$];
    int          errors, ticks, writes, frames, latches, checked;

    function new();
      foreach (frame[y, x]) frame[y][x] = '0;
      phase      = PH_SHIFT;
      row        = '0;
      col        = '0;
      hold_cnt   = '0;
      hold_ticks = HOLD_TICKS_RESET;
      errors     = 0;
      ticks      = 0;
      writes     = 0;
      frames     = 0;
      latches    = 0;
      checked    = 0;
    endfunction

    function void set_hold(logic [15:0] v);
      hold_ticks = v;
    endfunction

    // accepted input: update the frame buffer or predict the next pin word
    function void take_item(item_t it);
      pin_t        p;
      int unsigned limit;
      if (it.kind == KIND_PIXEL) begin
        frame[it.pixel_y][it.pixel_x] = it.pixel_colour;
        writes++;
        return;
      end
      ticks++;
      p              = '0;
      p.row_select   = row;
      p.output_blank = 1'b1;
      case (phase)
        PH_LATCH: begin
          p.latch_strobe = 1'b1;
          phase          = PH_HOLD;
          hold_cnt       = '0;
          latches++;
        end
        PH_HOLD: begin
          // zero hold behaves as a single lit tick
          limit          = (hold_ticks == 0) ? 1 : hold_ticks;
          p.output_blank = 1'b0;
          if (hold_cnt + 1 >= limit) begin
            if (row == ROWS - 1) begin
              p.frame_end = 1'b1;
              frames++;
              row = '0;
            end else begin
              row = row + 1'b1;
            end
            hold_cnt = '0;
            col      = '0;
            phase    = PH_SHIFT;
          end else begin
            hold_cnt++;
          end
        end
        default: begin
          p.top_colour    = frame[row][col];
          p.bottom_colour = frame[row + ROWS][col];
          p.shift_strobe  = 1'b1;
          if (col == COLS - 1) begin
            col   = '0;
            phase = PH_LATCH;
          end else begin
            col++;
          end
        end
      endcase
      pending_pins.push_back(p);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= PRINT_CAP) $display("mismatch: %s", msg);
    endtask

    function string field_msg(string name, logic [2:0] got, logic [2:0] want);
      return $sformatf("pin word %0d %s got %0d want %0d", checked, name, got, want);
    endfunction

    task check_pin(pin_t got);
      pin_t want;
      if (pending_pins.size() == 0) begin
        report($sformatf("pin word %h arrived with no tick waiting", got));
        return;
      end
      want = pending_pins.pop_front();
      checked++;
      if (got.top_colour !== want.top_colour)
        report(field_msg("top_colour", got.top_colour, want.top_colour));
      if (got.bottom_colour !== want.bottom_colour)
        report(field_msg("bottom_colour", got.bottom_colour, want.bottom_colour));
      if (got.row_select !== want.row_select)
        report(field_msg("row_select", got.row_select, want.row_select));
      if (got.shift_strobe !== want.shift_strobe)
        report(field_msg("shift_strobe", got.shift_strobe, want.shift_strobe));
      if (got.latch_strobe !== want.latch_strobe)
        report(field_msg("latch_strobe", got.latch_strobe, want.latch_strobe));
      if (got.output_blank !== want.output_blank)
        report(field_msg("output_blank", got.output_blank, want.output_blank));
      if (got.frame_end !== want.frame_end)
        report(field_msg("frame_end", got.frame_end, want.frame_end));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_ready;
  item_t       item;
  logic        pin_valid;
  logic        pin_ready;
  pin_t        pin;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  scan_pin_tracker tracker;
  bit              long_stall_req;
  int              long_stalls;
  int              idle_cycles;
  int              hold_settings;
  int              full_drains;

  rgb_led_matrix_scan_driver i_dut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .pin_valid  (pin_valid),
    .pin_ready  (pin_ready),
    .pin        (pin),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // every transfer is observed here; the watchdog counts cycles with none
  always @(posedge clk) begin
    if (!rst) begin
      if (pin_valid && pin_ready) tracker.check_pin(pin);
      if (item_valid && item_ready) tracker.take_item(item);
      if (cfg_valid && cfg_ready) tracker.set_hold(cfg_data);
      if ((pin_valid && pin_ready) || (item_valid && item_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: %0d cycles without a transfer, %0d pin words outstanding",
                 idle_cycles, tracker.pending_pins.size());
        $display("rgb_led_matrix_scan_driver verification failed");
        $finish;
      end
    end
  end

  // output side: random stretches of stall modes, plus one long hold-off on request
  initial begin : pin_sink
    int stretch, mode, stall_left;
    stretch    = 0;
    mode       = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        pin_ready <= 1'b0;
      end else if (long_stall_req) begin
        long_stall_req = 1'b0;
        long_stalls++;
        stall_left = LONG_STALL - 1;
        pin_ready <= 1'b0;
      end else begin
        if (stretch == 0) begin
          stretch = $urandom_range(4, 64);
          mode    = $urandom_range(3);
        end
        stretch--;
        case (mode)
          0:       pin_ready <= 1'b1;
          1:       pin_ready <= 1'($urandom_range(1));
          2:       pin_ready <= ($urandom_range(3) == 0);
          default: pin_ready <= (stretch % 3 != 0);
        endcase
      end
    end
  end

  task automatic send_item(item_t it);
    @(negedge clk);
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (!item_ready);
  endtask

  task automatic pause_items(int n);
    @(negedge clk);
    item_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // stop sending and wait for every predicted pin word, then let writes settle
  task automatic drain();
    pause_items(1);
    while (tracker.pending_pins.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_hold(logic [15:0] v);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    hold_settings++;
  endtask

  function automatic item_t make_item(logic kind, int x, int y, int c);
    item_t it;
    it.kind         = kind;
    it.pixel_x      = 5'(x);
    it.pixel_y      = 4'(y);
    it.pixel_colour = 3'(c);
    return it;
  endfunction

  function automatic item_t random_item(int tick_pct);
    logic kind;
    kind = ($urandom_range(99) < tick_pct) ? KIND_TICK : KIND_PIXEL;
    return make_item(kind, $urandom, $urandom, $urandom);
  endfunction

  // bursts of random items with random gaps; optional long output stall and full drain
  task automatic run_random(int count, int tick_pct, bit with_stall, int drain_at);
    int burst, gap_kind, stall_at;
    stall_at = with_stall ? $urandom_range(count / 4, count / 2) : -1;
    while (count > 0) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && count > 0; i++) begin
        if (count == stall_at) long_stall_req = 1'b1;
        if (count == drain_at) begin
          drain();
          full_drains++;
        end
        send_item(random_item(tick_pct));
        count--;
      end
      gap_kind = $urandom_range(3);
      case (gap_kind)
        0:       ; // back to back
        1, 2:    pause_items($urandom_range(1, 6));
        default: pause_items($urandom_range(8, 30));
      endcase
    end
  endtask

  initial begin : stimulus
    rst            = 1'b1;
    item_valid     = 1'b0;
    item           = '0;
    pin_ready      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    long_stall_req = 1'b0;
    long_stalls    = 0;
    idle_cycles    = 0;
    hold_settings  = 0;
    full_drains    = 0;
    tracker        = new();
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // zero hold first, then corner pixels and the start of row 0
    write_hold(16'd0);
    send_item(make_item(KIND_PIXEL, 0, 0, 7));
    send_item(make_item(KIND_PIXEL, 31, 0, 1));
    send_item(make_item(KIND_PIXEL, 0, 8, 2));
    send_item(make_item(KIND_PIXEL, 1, 8, 4));
    send_item(make_item(KIND_PIXEL, 1, 0, 5));
    send_item(make_item(KIND_PIXEL, 2, 15, 6));
    send_item(make_item(KIND_PIXEL, 3, 7, 3));
    send_item(make_item(KIND_PIXEL, 31, 15, 7));
    repeat (16) send_item(make_item(KIND_TICK, 0, 0, 0));

    write_hold(16'd1);
    run_random(200, 85, 1'b1, -1);
    write_hold(16'hFFFF);
    run_random(40, 70, 1'b0, -1);
    write_hold(16'd2);
    run_random(150, 80, 1'b0, 75);
    write_hold(16'd0);
    run_random(120, 80, 1'b1, -1);
    write_hold(16'($urandom_range(3, 12)));
    run_random(120, 75, 1'b0, -1);
    write_hold(16'd100);
    run_random(150, 90, 1'b0, -1);
    write_hold(16'($urandom_range(1, 40)));
    run_random(80, 60, 1'b1, 40);

    drain();
    repeat (8) @(posedge clk);
    if (tracker.pending_pins.size() != 0)
      tracker.report($sformatf("%0d pin words never arrived", tracker.pending_pins.size()));

    $display("covered %0d writes, %0d ticks, %0d rows latched, %0d frames, %0d hold settings",
             tracker.writes, tracker.ticks, tracker.latches, tracker.frames, hold_settings);
    $display("%0d long output stalls, %0d full drains, %0d pin words checked, %0d mismatches",
             long_stalls, full_drains, tracker.checked, tracker.errors);
    if (tracker.errors == 0)
      $display("rgb_led_matrix_scan_driver verification clean");
    else
      $display("rgb_led_matrix_scan_driver verification failed");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+sv
sv/rlmsd_pkg.sv
sv/rgb_led_matrix_scan_driver.sv
test/rgb_led_matrix_scan_driver_tb.sv
